// ===== rtl/htkv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package htkv_pkg;

    localparam int TOP_BITS_DEF   = 8;
    localparam int NODE_COUNT_DEF = 1024;

    // murmur3 finalizer constants
    localparam int          MIX_SHIFT = 33;
    localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_UPSERT = 2'd1;
    localparam logic [1:0] CMD_INSERT = 2'd2;
    localparam logic [1:0] CMD_RSVD   = 2'd3;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_LINK,
        S_CMP,
        S_FIX,
        S_DONE
    } state_t;

    function automatic logic [63:0] mix_xs(input logic [63:0] x);
        return x ^ (x >> MIX_SHIFT);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/htkv_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module htkv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/htkv_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Low 64 bits of a 64x64 product from one 32x32 multiplier.
module htkv_mul (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      product
);

    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] mul;

    // step 0: aL*bL, step 1: aL*bH, step 2: aH*bL; the aH*bH term drops out
    always_comb begin
        op_a = (step_reg == 2'd2) ? a_reg[63:32] : a_reg[31:0];
        op_b = (step_reg == 2'd1) ? b_reg[63:32] : b_reg[31:0];
        mul  = 64'(op_a) * 64'(op_b);
    end

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = a;
            b_next    = b;
            step_next = 2'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            prod_next = mul;
            step_next = step_reg + 2'd1;
            case (step_reg)
                2'd0: acc_next = acc_reg;
                2'd1: acc_next = prod_reg;
                default: acc_next = acc_reg + {prod_reg[31:0], 32'd0};
            endcase
            if (step_reg == 2'd3) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/hash_trie_key_value_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Insert-only 64-bit key/value map kept as a 4-ary hash trie.
// Input word (s_cmd, s_key, s_value) on a valid/ready channel: cmd 0 lookup,
// 1 upsert, 2 insert zero if absent, 3 acts as lookup. One result word per
// input (m_found, m_result_value, m_status) on a valid/ready channel.
// One word is worked on at a time; s_ready is high only while idle.
// Flow: the key goes through two mixer multiplies on the one shared 32x32
// multiplier, then the trie walk reads the node memories and compares the
// key for each node visited, at most (64-TOP_BITS)/2 + 1 nodes; where needed
// a new node and its parent link are then written before the result is
// loaded into the output register.
// The next word can be accepted as soon as the result is loaded there.
// The result sits in an output register: a stalled m_ready does not block
// the next input word, only the finish of that word's own result.
// Reset: after aresetn is released the root table is swept to empty,
// one entry per cycle over all 2^TOP_BITS entries, with s_ready low meanwhile.
// Node store holds NODE_COUNT-1 entries; an insert past that returns
// status 1. Keys are matched on the key alone: the mixer is bijective, so
// a key match implies a hash match and the hash is not stored.
module hash_trie_key_value_store #(
    parameter int TOP_BITS   = htkv_pkg::TOP_BITS_DEF,
    parameter int NODE_COUNT = htkv_pkg::NODE_COUNT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [63:0] s_key,
    input  wire logic [63:0] s_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_found,
    output logic [63:0]      m_result_value,
    output logic             m_status
);

    localparam int LW         = $clog2(NODE_COUNT);
    localparam int KW         = 4 * LW;
    localparam int RA_W       = (TOP_BITS == 0) ? 1 : TOP_BITS;
    localparam int ROOT_COUNT = 1 << TOP_BITS;

    htkv_pkg::state_t state_reg, state_next;
    logic [RA_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [LW:0]      next_free_reg, next_free_next;
    logic [1:0]       cmd_reg, cmd_next;
    logic [63:0]      key_reg, key_next;
    logic [63:0]      value_reg, value_next;
    logic [RA_W-1:0]  root_idx_reg, root_idx_next;
    logic [63:0]      h_reg, h_next;
    logic             at_root_reg, at_root_next;
    logic [1:0]       sel_reg, sel_next;
    logic [LW-1:0]    cur_reg, cur_next;
    logic [LW-1:0]    parent_reg, parent_next;
    logic [KW-1:0]    kids_reg, kids_next;
    logic             res_found_reg, res_found_next;
    logic [63:0]      res_value_reg, res_value_next;
    logic             res_status_reg, res_status_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_found_reg, m_found_next;
    logic [63:0]      m_value_reg, m_value_next;
    logic             m_status_reg, m_status_next;

    // shared multiplier
    logic        mul_start;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic        mul_done;
    logic [63:0] mul_prod;

    // memories
    logic              root_we, root_re;
    logic [RA_W-1:0]   root_waddr, root_raddr;
    logic [LW-1:0]     root_wdata, root_rdata;
    logic              kid_we, kid_re;
    logic [LW-1:0]     kid_waddr, kid_raddr;
    logic [KW-1:0]     kid_wdata, kid_rdata;
    logic              kv_we, kv_re;
    logic [LW-1:0]     kv_waddr, kv_raddr;
    logic [127:0]      kv_wdata, kv_rdata;

    logic [63:0]   hash_c;
    logic [LW-1:0] link;
    logic          link_empty;
    logic          store_full;
    logic [KW-1:0] kids_fixed;

    htkv_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    htkv_ram #(.WIDTH(LW), .DEPTH(ROOT_COUNT)) u_root_ram (
        .aclk  (aclk),
        .we    (root_we),
        .waddr (root_waddr),
        .wdata (root_wdata),
        .re    (root_re),
        .raddr (root_raddr),
        .rdata (root_rdata)
    );

    htkv_ram #(.WIDTH(KW), .DEPTH(NODE_COUNT)) u_kid_ram (
        .aclk  (aclk),
        .we    (kid_we),
        .waddr (kid_waddr),
        .wdata (kid_wdata),
        .re    (kid_re),
        .raddr (kid_raddr),
        .rdata (kid_rdata)
    );

    // {key, value}
    htkv_ram #(.WIDTH(128), .DEPTH(NODE_COUNT)) u_kv_ram (
        .aclk  (aclk),
        .we    (kv_we),
        .waddr (kv_waddr),
        .wdata (kv_wdata),
        .re    (kv_re),
        .raddr (kv_raddr),
        .rdata (kv_rdata)
    );

    always_comb begin
        hash_c     = htkv_pkg::mix_xs(mul_prod);
        link       = at_root_reg ? root_rdata : kids_reg[sel_reg*LW +: LW];
        link_empty = (link == '0) || ({1'b0, link} >= (LW+1)'(NODE_COUNT));
        store_full = (next_free_reg >= (LW+1)'(NODE_COUNT));
        for (int i = 0; i < 4; i++) begin
            kids_fixed[i*LW +: LW] = (sel_reg == 2'(i)) ? cur_reg : kids_reg[i*LW +: LW];
        end
    end

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        next_free_next  = next_free_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        root_idx_next   = root_idx_reg;
        h_next          = h_reg;
        at_root_next    = at_root_reg;
        sel_next        = sel_reg;
        cur_next        = cur_reg;
        parent_next     = parent_reg;
        kids_next       = kids_reg;
        res_found_next  = res_found_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_found_next    = m_found_reg;
        m_value_next    = m_value_reg;
        m_status_next   = m_status_reg;

        mul_start  = 1'b0;
        mul_a      = htkv_pkg::mix_xs(mul_prod);
        mul_b      = htkv_pkg::MIX_C2;
        root_we    = 1'b0;
        root_waddr = root_idx_reg;
        root_wdata = next_free_reg[LW-1:0];
        root_re    = 1'b0;
        root_raddr = RA_W'(hash_c >> (64 - TOP_BITS));
        kid_we     = 1'b0;
        kid_waddr  = next_free_reg[LW-1:0];
        kid_wdata  = '0;
        kid_re     = 1'b0;
        kid_raddr  = link;
        kv_we      = 1'b0;
        kv_waddr   = next_free_reg[LW-1:0];
        kv_wdata   = {key_reg, value_reg};
        kv_re      = 1'b0;
        kv_raddr   = link;

        unique case (state_reg)
            htkv_pkg::S_CLEAR: begin
                root_we    = 1'b1;
                root_waddr = clr_cnt_reg;
                root_wdata = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == RA_W'(ROOT_COUNT - 1)) begin
                    state_next = htkv_pkg::S_IDLE;
                end
            end
            htkv_pkg::S_IDLE: begin
                if (s_valid) begin
                    cmd_next   = (s_cmd == htkv_pkg::CMD_RSVD) ? htkv_pkg::CMD_LOOKUP : s_cmd;
                    key_next   = s_key;
                    value_next = s_value;
                    mul_start  = 1'b1;
                    mul_a      = htkv_pkg::mix_xs(s_key);
                    mul_b      = htkv_pkg::MIX_C1;
                    state_next = htkv_pkg::S_MUL1;
                end
            end
            htkv_pkg::S_MUL1: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    state_next = htkv_pkg::S_MUL2;
                end
            end
            htkv_pkg::S_MUL2: begin
                if (mul_done) begin
                    root_re       = 1'b1;
                    root_idx_next = root_raddr;
                    h_next        = hash_c << TOP_BITS;
                    at_root_next  = 1'b1;
                    state_next    = htkv_pkg::S_LINK;
                end
            end
            htkv_pkg::S_LINK: begin
                if (!link_empty) begin
                    kv_re      = 1'b1;
                    kid_re     = 1'b1;
                    cur_next   = link;
                    state_next = htkv_pkg::S_CMP;
                end else if (cmd_reg == htkv_pkg::CMD_LOOKUP) begin
                    res_found_next  = 1'b0;
                    res_value_next  = '0;
                    res_status_next = htkv_pkg::STATUS_OK;
                    state_next      = htkv_pkg::S_DONE;
                end else if (store_full) begin
                    res_found_next  = 1'b0;
                    res_value_next  = '0;
                    res_status_next = htkv_pkg::STATUS_FULL;
                    state_next      = htkv_pkg::S_DONE;
                end else begin
                    // new node: key/value and empty links, then hook into parent
                    kv_we    = 1'b1;
                    kv_wdata = {key_reg,
                                (cmd_reg == htkv_pkg::CMD_UPSERT) ? value_reg : 64'd0};
                    kid_we   = 1'b1;
                    cur_next       = next_free_reg[LW-1:0];
                    next_free_next = next_free_reg + 1'b1;
                    res_found_next  = 1'b0;
                    res_value_next  = (cmd_reg == htkv_pkg::CMD_UPSERT) ? value_reg : 64'd0;
                    res_status_next = htkv_pkg::STATUS_OK;
                    if (at_root_reg) begin
                        root_we    = 1'b1;
                        state_next = htkv_pkg::S_DONE;
                    end else begin
                        state_next = htkv_pkg::S_FIX;
                    end
                end
            end
            htkv_pkg::S_CMP: begin
                if (kv_rdata[127:64] == key_reg) begin
                    res_found_next  = 1'b1;
                    res_status_next = htkv_pkg::STATUS_OK;
                    if (cmd_reg == htkv_pkg::CMD_UPSERT) begin
                        kv_we          = 1'b1;
                        kv_waddr       = cur_reg;
                        res_value_next = value_reg;
                    end else begin
                        res_value_next = kv_rdata[63:0];
                    end
                    state_next = htkv_pkg::S_DONE;
                end else begin
                    kids_next    = kid_rdata;
                    parent_next  = cur_reg;
                    sel_next     = h_reg[63:62];
                    h_next       = h_reg << 2;
                    at_root_next = 1'b0;
                    state_next   = htkv_pkg::S_LINK;
                end
            end
            htkv_pkg::S_FIX: begin
                kid_we     = 1'b1;
                kid_waddr  = parent_reg;
                kid_wdata  = kids_fixed;
                state_next = htkv_pkg::S_DONE;
            end
            htkv_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_found_next  = res_found_reg;
                    m_value_next  = res_value_reg;
                    m_status_next = res_status_reg;
                    state_next    = htkv_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = htkv_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= htkv_pkg::S_CLEAR;
            clr_cnt_reg   <= '0;
            next_free_reg <= (LW+1)'(1);
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            next_free_reg <= next_free_next;
            m_valid_reg   <= m_valid_next;
        end
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        root_idx_reg   <= root_idx_next;
        h_reg          <= h_next;
        at_root_reg    <= at_root_next;
        sel_reg        <= sel_next;
        cur_reg        <= cur_next;
        parent_reg     <= parent_next;
        kids_reg       <= kids_next;
        res_found_reg  <= res_found_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_found_reg    <= m_found_next;
        m_value_reg    <= m_value_next;
        m_status_reg   <= m_status_next;
    end

    assign s_ready        = (state_reg == htkv_pkg::S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_result_value = m_value_reg;
    assign m_status       = m_status_reg;

endmodule

`default_nettype wire

// ===== rtl/htkv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module htkv_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_found,
    input wire logic [63:0] m_result_value,
    input wire logic        m_status
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found)
            && $stable(m_result_value) && $stable(m_status))
        else $error("result word changed while stalled");

    // a failed insert reports nothing found and a zero value
    a_full_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> !m_found && (m_result_value == 64'd0))
        else $error("full status with found or nonzero value");

    // a hit never needs a node, so it cannot report full
    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> !m_status)
        else $error("hit reported with full status");

    // one word in flight: ready drops right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while busy");

endmodule

bind hash_trie_key_value_store htkv_checker u_checker (.*);

`default_nettype wire

// ===== verif/tb_hash_trie_key_value_store.sv =====
`timescale 1ns / 1ps

module tb_hash_trie_key_value_store;

    localparam int TOP_BITS   = htkv_pkg::TOP_BITS_DEF;
    localparam int NODE_COUNT = htkv_pkg::NODE_COUNT_DEF;
    localparam int ROOT_SLOTS = 1 << TOP_BITS;
    localparam int LEVELS     = (64 - TOP_BITS) / 2;

    typedef struct packed {
        logic        found;
        logic [63:0] value;
        logic        status;
    } trie_reply_t;

    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd          = htkv_pkg::CMD_LOOKUP;
    logic [63:0] s_key          = '0;
    logic [63:0] s_value        = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic        m_found;
    logic [63:0] m_result_value;
    logic        m_status;

    hash_trie_key_value_store u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_key          (s_key),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_result_value (m_result_value),
        .m_status       (m_status)
    );

    // shadow trie
    int          root_link  [ROOT_SLOTS];
    int          child_link [NODE_COUNT][4];
    logic [63:0] node_key_m [NODE_COUNT];
    logic [63:0] node_val_m [NODE_COUNT];
    int          next_node = 1;

    trie_reply_t pending_replies[$];
    logic [63:0] stored_keys[$];
    int unsigned fail_count    = 0;
    bit          idle_on       = 1'b1;
    int          stall_request = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] mix_key(logic [63:0] k);
        k = k ^ (k >> htkv_pkg::MIX_SHIFT);
        k = k * htkv_pkg::MIX_C1;
        k = k ^ (k >> htkv_pkg::MIX_SHIFT);
        k = k * htkv_pkg::MIX_C2;
        k = k ^ (k >> htkv_pkg::MIX_SHIFT);
        return k;
    endfunction

    // inverse mod 2^64 by Newton steps; each step doubles the good low bits
    function automatic logic [63:0] odd_inverse(logic [63:0] c);
        logic [63:0] x;
        x = c;
        repeat (6) x = x * (64'd2 - c * x);
        return x;
    endfunction

    // undo the mixer so a key can be built for a chosen hash
    function automatic logic [63:0] key_for_hash(logic [63:0] h);
        h = h ^ (h >> htkv_pkg::MIX_SHIFT);
        h = h * odd_inverse(htkv_pkg::MIX_C2);
        h = h ^ (h >> htkv_pkg::MIX_SHIFT);
        h = h * odd_inverse(htkv_pkg::MIX_C1);
        h = h ^ (h >> htkv_pkg::MIX_SHIFT);
        return h;
    endfunction

    function automatic trie_reply_t predict_trie_op(logic [1:0] cmd, logic [63:0] key,
                                                   logic [63:0] value);
        trie_reply_t res;
        logic [63:0] hval;
        logic [63:0] path;
        logic [1:0]  op;
        int          root;
        int          cur;
        int          parent;
        int          branch;
        int          n;
        res    = '0;
        op     = (cmd == htkv_pkg::CMD_RSVD) ? htkv_pkg::CMD_LOOKUP : cmd;
        hval   = mix_key(key);
        path   = hval << TOP_BITS;
        root   = (TOP_BITS == 0) ? 0 : int'(hval >> (64 - TOP_BITS));
        cur    = root_link[root];
        parent = -1;
        branch = 0;
        for (int steps = 0; steps <= NODE_COUNT && cur != 0 && cur < NODE_COUNT; steps++) begin
            if (node_key_m[cur] == key) begin
                if (op == htkv_pkg::CMD_UPSERT)
                    node_val_m[cur] = value;
                res.found = 1'b1;
                res.value = node_val_m[cur];
                return res;
            end
            parent = cur;
            branch = int'(path[63:62]);
            path   = path << 2;
            cur    = child_link[cur][branch];
        end
        if (op == htkv_pkg::CMD_LOOKUP)
            return res;
        if (next_node >= NODE_COUNT) begin
            res.status = htkv_pkg::STATUS_FULL;
            return res;
        end
        n = next_node;
        next_node++;
        for (int c = 0; c < 4; c++)
            child_link[n][c] = 0;
        node_key_m[n] = key;
        node_val_m[n] = (op == htkv_pkg::CMD_UPSERT) ? value : '0;
        if (parent < 0)
            root_link[root] = n;
        else
            child_link[parent][branch] = n;
        res.value = node_val_m[n];
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int idle_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] pick_stored_key();
        return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    endfunction

    task automatic send_word(logic [1:0] cmd, logic [63:0] key, logic [63:0] value);
        int          gap;
        trie_reply_t reply;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_key   <= key;
        s_value <= value;
        do @(posedge aclk); while (s_ready !== 1'b1);
        reply = predict_trie_op(cmd, key, value);
        pending_replies.push_back(reply);
        if (!reply.found && reply.status == htkv_pkg::STATUS_OK &&
            (cmd == htkv_pkg::CMD_UPSERT || cmd == htkv_pkg::CMD_INSERT))
            stored_keys.push_back(key);
    endtask

    // sender holds off until every reply is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_replies.size() != 0);
    endtask

    task automatic send_random_word();
        int          r;
        logic [1:0]  cmd;
        logic [63:0] key;
        logic [63:0] value;
        r = $urandom_range(0, 99);
        if (r < 30)
            cmd = htkv_pkg::CMD_LOOKUP;
        else if (r < 65)
            cmd = htkv_pkg::CMD_UPSERT;
        else if (r < 90)
            cmd = htkv_pkg::CMD_INSERT;
        else
            cmd = htkv_pkg::CMD_RSVD;
        key   = ($urandom_range(0, 99) < 55) ? pick_stored_key() : rand64();
        r     = $urandom_range(0, 99);
        value = (r < 4) ? '0 : (r < 8) ? '1 : rand64();
        send_word(cmd, key, value);
    endtask

    task automatic test_command_corners();
        send_word(htkv_pkg::CMD_LOOKUP, '0, '0);
        send_word(htkv_pkg::CMD_LOOKUP, '1, '1);
        send_word(htkv_pkg::CMD_INSERT, '0, '1);          // value field ignored, stores zero
        send_word(htkv_pkg::CMD_UPSERT, '1, '1);
        send_word(htkv_pkg::CMD_LOOKUP, '1, '0);
        send_word(htkv_pkg::CMD_RSVD, '1, '0);            // reserved code acts as lookup
        send_word(htkv_pkg::CMD_RSVD, 64'd1, '1);         // miss, must not insert
        send_word(htkv_pkg::CMD_LOOKUP, 64'd1, '0);
        send_word(htkv_pkg::CMD_INSERT, '1, 64'h1234);    // hit, stored value untouched
        send_word(htkv_pkg::CMD_UPSERT, '0, 64'h5555_5555_5555_5555);
        send_word(htkv_pkg::CMD_LOOKUP, '0, '1);
        send_word(htkv_pkg::CMD_UPSERT, '0, '0);
        send_word(htkv_pkg::CMD_UPSERT, 64'h8000_0000_0000_0000, 64'd1);
        send_word(htkv_pkg::CMD_INSERT, 64'd1, '1);
        send_word(htkv_pkg::CMD_UPSERT, 64'd1, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(htkv_pkg::CMD_INSERT, 64'd1, '0);
        send_word(htkv_pkg::CMD_RSVD, 64'h8000_0000_0000_0000, '0);
        send_word(htkv_pkg::CMD_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, '0);
    endtask

    // Keys whose hashes share ever longer prefixes, so each insert lands one
    // level deeper; the last one walks the whole chain down to the final
    // level, where only the two lowest hash bits are left.
    task automatic test_deep_chain();
        logic [63:0] base;
        logic [63:0] chain[LEVELS + 1];
        logic [1:0]  cmd;
        int          lvl;
        base = rand64();
        for (int i = 0; i < LEVELS; i++)
            chain[i] = key_for_hash(base ^ (64'd1 << (63 - TOP_BITS - 2 * i)));
        chain[LEVELS] = key_for_hash(base);
        foreach (chain[i])
            send_word(($urandom_range(0, 1) != 0) ? htkv_pkg::CMD_UPSERT : htkv_pkg::CMD_INSERT,
                      chain[i], rand64());
        foreach (chain[i]) begin
            cmd = 2'($urandom_range(0, 3));
            send_word(cmd, chain[i], rand64());
        end
        // misses that follow the chain before falling off it
        for (int i = 0; i < 12; i++) begin
            lvl = $urandom_range(0, LEVELS - 1);
            send_word(htkv_pkg::CMD_LOOKUP,
                      key_for_hash(base ^ (64'd1 << (62 - TOP_BITS - 2 * lvl))), rand64());
        end
        for (int i = 0; i < 4; i++) begin
            lvl = $urandom_range(LEVELS - 4, LEVELS - 1);
            send_word(htkv_pkg::CMD_INSERT,
                      key_for_hash(base ^ (64'd3 << (62 - TOP_BITS - 2 * lvl))), '0);
        end
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < 200; i++) begin
            // every third block of words runs with no gaps on either side
            idle_on = ((i / 50) % 3) != 2;
            send_random_word();
        end
        idle_on = 1'b1;
    endtask

    task automatic test_output_stall();
        wait_drained();
        idle_on       = 1'b0;
        stall_request = 400;
        for (int i = 0; i < 8; i++)
            send_random_word();
        wait_drained();
        idle_on = 1'b1;
    endtask

    task automatic test_store_full();
        while (next_node < NODE_COUNT)
            send_word(($urandom_range(0, 1) != 0) ? htkv_pkg::CMD_UPSERT : htkv_pkg::CMD_INSERT,
                      rand64(), rand64());
        for (int i = 0; i < 8; i++)
            send_word(2'($urandom_range(0, 3)), rand64(), rand64());
        for (int i = 0; i < 40; i++)
            send_random_word();
    endtask

    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (stall_request > 0) begin
                hold_left     = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall_left = ($urandom_range(0, 3) == 0) ? idle_gap() : 0;
            end
        end
    end

    always @(posedge aclk) begin
        trie_reply_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_replies.size() == 0) begin
                $error("result word with no request pending");
                fail_count++;
            end else begin
                want = pending_replies.pop_front();
                if (m_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, m_found);
                    fail_count++;
                end
                if (m_result_value !== want.value) begin
                    $error("result_value: expected %h, got %h", want.value, m_result_value);
                    fail_count++;
                end
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #(20_000_000);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_command_corners();
        wait_drained();
        test_deep_chain();
        wait_drained();
        test_random_traffic();
        test_output_stall();
        test_store_full();
        wait_drained();
        repeat (100) @(posedge aclk);
        if (fail_count == 0 && pending_replies.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
